/* src/qrm_pkg.sv */
// Package for the quaternion rotation and motion flag block.
// Holds shared widths, reset values, register codes and the types passed between modules.
// Depends on nothing.
package qrm_pkg;

    localparam int DATA_W = 16;
    localparam int ANGLE_W = 15;
    localparam int CFG_INDEX_W = 3;
    localparam int ACOS_INDEX_BITS_DEFAULT = 12;
    localparam logic [ANGLE_W-1:0] ANGLE_MAX = 15'd18000;

    localparam logic signed [DATA_W-1:0] LIMIT_ABOVE_RESET = 16'sd512;
    localparam logic signed [DATA_W-1:0] LIMIT_BELOW_RESET = -16'sd512;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LIFT     = 3'd0,
        REG_DROP     = 3'd1,
        REG_LEFT     = 3'd2,
        REG_RIGHT    = 3'd3,
        REG_FORWARD  = 3'd4,
        REG_BACKWARD = 3'd5
    } cfg_reg_e;

    typedef struct packed {
        logic backward;
        logic forward;
        logic right;
        logic left;
        logic drop;
        logic lift;
    } flags_t;

    typedef struct packed {
        logic take;
        logic angle;
    } rot_kind_t;

endpackage

/* src/qrm_sample_if.sv */
// Input channel of the quaternion rotation and motion flag block.
// Carries valid, ready and the fields of one sensor event item; uses qrm_pkg.
interface qrm_sample_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  operation;
    logic                                  sensor_was_reset;
    logic signed [qrm_pkg::DATA_W-1:0]     accel_x;
    logic signed [qrm_pkg::DATA_W-1:0]     accel_y;
    logic signed [qrm_pkg::DATA_W-1:0]     accel_z;
    logic signed [qrm_pkg::DATA_W-1:0]     quat_w;
    logic signed [qrm_pkg::DATA_W-1:0]     quat_x;
    logic signed [qrm_pkg::DATA_W-1:0]     quat_y;
    logic signed [qrm_pkg::DATA_W-1:0]     quat_z;

    modport source (
        output valid, operation, sensor_was_reset, accel_x, accel_y, accel_z,
               quat_w, quat_x, quat_y, quat_z,
        input  ready
    );

    modport sink (
        input  valid, operation, sensor_was_reset, accel_x, accel_y, accel_z,
               quat_w, quat_x, quat_y, quat_z,
        output ready
    );
endinterface

/* src/qrm_result_if.sv */
// Output channel of the quaternion rotation and motion flag block.
// Carries valid, ready and the fields of one result item; uses qrm_pkg.
interface qrm_result_if;
    logic                           valid;
    logic                           ready;
    logic                           angle_valid;
    logic [qrm_pkg::ANGLE_W-1:0]    angle_centideg;
    logic                           reference_taken;
    logic                           lift_flag;
    logic                           drop_flag;
    logic                           left_flag;
    logic                           right_flag;
    logic                           forward_flag;
    logic                           backward_flag;

    modport source (
        output valid, angle_valid, angle_centideg, reference_taken, lift_flag, drop_flag,
               left_flag, right_flag, forward_flag, backward_flag,
        input  ready
    );

    modport sink (
        input  valid, angle_valid, angle_centideg, reference_taken, lift_flag, drop_flag,
               left_flag, right_flag, forward_flag, backward_flag,
        output ready
    );
endinterface

/* src/qrm_motion.sv */
// Limit registers and motion flags of the quaternion rotation block.
// Compares accelerations with the six limits and holds the flags; uses qrm_pkg.
module qrm_motion (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [qrm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [qrm_pkg::DATA_W-1:0]          cfg_data,
    input  logic                                accel_accept,
    input  logic signed [qrm_pkg::DATA_W-1:0]   accel_x,
    input  logic signed [qrm_pkg::DATA_W-1:0]   accel_y,
    input  logic signed [qrm_pkg::DATA_W-1:0]   accel_z,
    output qrm_pkg::flags_t                     flags
);

    logic signed [qrm_pkg::DATA_W-1:0] lift_limit_reg;
    logic signed [qrm_pkg::DATA_W-1:0] drop_limit_reg;
    logic signed [qrm_pkg::DATA_W-1:0] left_limit_reg;
    logic signed [qrm_pkg::DATA_W-1:0] right_limit_reg;
    logic signed [qrm_pkg::DATA_W-1:0] forward_limit_reg;
    logic signed [qrm_pkg::DATA_W-1:0] backward_limit_reg;
    qrm_pkg::flags_t                   flags_reg;
    qrm_pkg::flags_t                   flags_next;
    qrm_pkg::flags_t                   compare;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lift_limit_reg     <= qrm_pkg::LIMIT_ABOVE_RESET;
            drop_limit_reg     <= qrm_pkg::LIMIT_BELOW_RESET;
            left_limit_reg     <= qrm_pkg::LIMIT_ABOVE_RESET;
            right_limit_reg    <= qrm_pkg::LIMIT_BELOW_RESET;
            forward_limit_reg  <= qrm_pkg::LIMIT_ABOVE_RESET;
            backward_limit_reg <= qrm_pkg::LIMIT_BELOW_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                qrm_pkg::REG_LIFT:     lift_limit_reg     <= $signed(cfg_data);
                qrm_pkg::REG_DROP:     drop_limit_reg     <= $signed(cfg_data);
                qrm_pkg::REG_LEFT:     left_limit_reg     <= $signed(cfg_data);
                qrm_pkg::REG_RIGHT:    right_limit_reg    <= $signed(cfg_data);
                qrm_pkg::REG_FORWARD:  forward_limit_reg  <= $signed(cfg_data);
                qrm_pkg::REG_BACKWARD: backward_limit_reg <= $signed(cfg_data);
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        compare.lift     = accel_z > lift_limit_reg;
        compare.drop     = accel_z < drop_limit_reg;
        compare.left     = accel_x > left_limit_reg;
        compare.right    = accel_x < right_limit_reg;
        compare.forward  = accel_y > forward_limit_reg;
        compare.backward = accel_y < backward_limit_reg;
        flags_next       = accel_accept ? compare : flags_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    assign flags = flags_next;

endmodule

/* src/qrm_dot.sv */
// Reference quaternion store and dot product of the quaternion rotation block.
// Registers the four products when an angle item is accepted, then sums, clamps
// and scales them to a table index; uses qrm_pkg.
module qrm_dot #(
    parameter int INDEX_BITS = qrm_pkg::ACOS_INDEX_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  logic                                operation,
    input  logic                                sensor_was_reset,
    input  logic signed [qrm_pkg::DATA_W-1:0]   quat_w,
    input  logic signed [qrm_pkg::DATA_W-1:0]   quat_x,
    input  logic signed [qrm_pkg::DATA_W-1:0]   quat_y,
    input  logic signed [qrm_pkg::DATA_W-1:0]   quat_z,
    output qrm_pkg::rot_kind_t                  kind,
    output logic [INDEX_BITS:0]                 index
);

    localparam int PROD_W = 2 * qrm_pkg::DATA_W;
    localparam int SUM_W = PROD_W + 2;
    localparam int FRAC_BITS = 14;
    localparam int DOT_W = FRAC_BITS + 1;
    localparam int WIDE_W = DOT_W + 16;
    localparam logic signed [SUM_W-1:0] ONE_Q28 = SUM_W'(64'sd1 <<< (2 * FRAC_BITS));
    localparam logic [DOT_W-1:0] ONE_Q14 = DOT_W'(1 << FRAC_BITS);

    logic signed [qrm_pkg::DATA_W-1:0] quat_in [4];
    logic signed [qrm_pkg::DATA_W-1:0] ref_reg [4];
    logic signed [PROD_W-1:0]          prod_reg [4];
    logic                              held_reg;
    logic                              held_next;
    logic                              held_now;
    logic signed [SUM_W-1:0]           sum;
    logic [DOT_W-1:0]                  dot14;
    logic [WIDE_W-1:0]                 index_wide;

    assign quat_in[0] = quat_w;
    assign quat_in[1] = quat_x;
    assign quat_in[2] = quat_y;
    assign quat_in[3] = quat_z;

    assign held_now   = held_reg && !sensor_was_reset;
    assign kind.take  = operation && !held_now;
    assign kind.angle = operation && held_now;

    always_comb
    begin
        held_next = held_reg;
        if (accept)
        begin
            if (operation)
            begin
                held_next = 1'b1;
            end
            else if (sensor_was_reset)
            begin
                held_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 1'b0;
        end
        else
        begin
            held_reg <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && kind.take)
        begin
            for (int j = 0; j < 4; j++)
            begin
                ref_reg[j] <= quat_in[j];
            end
        end
        if (accept && kind.angle)
        begin
            for (int j = 0; j < 4; j++)
            begin
                prod_reg[j] <= ref_reg[j] * quat_in[j];
            end
        end
    end

    always_comb
    begin
        sum = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]) + SUM_W'(prod_reg[2])
            + SUM_W'(prod_reg[3]);
        if (sum <= 0)
        begin
            dot14 = '0;
        end
        else if (sum >= ONE_Q28)
        begin
            dot14 = ONE_Q14;
        end
        else
        begin
            dot14 = {1'b0, sum[2*FRAC_BITS-1:FRAC_BITS]};
        end
        index_wide = (WIDE_W'(dot14) << INDEX_BITS) >> FRAC_BITS;
    end

    assign index = index_wide[INDEX_BITS:0];

endmodule

/* src/qrm_acos_rom.sv */
// Angle table of the quaternion rotation block: 2*acos(i/2^INDEX_BITS) in centidegrees.
// The table is built at elaboration and read with a registered output; uses qrm_pkg.
module qrm_acos_rom #(
    parameter int INDEX_BITS = qrm_pkg::ACOS_INDEX_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            read_en,
    input  logic [INDEX_BITS:0]             addr,
    output logic [qrm_pkg::ANGLE_W-1:0]     data
);

    localparam int ENTRIES = (1 << INDEX_BITS) + 1;
    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;
    localparam logic [63:0] TAYLOR_DIV [10] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306, 64'd380
    };

    // Cosine of half a centidegree angle in Q30, by a truncating eleven-term series.
    function automatic logic signed [63:0] cos_q30(input logic [qrm_pkg::ANGLE_W-1:0] a);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        x    = (64'(a) * PI_Q30) / 64'd36000;
        x2   = (x * x) >> 30;
        term = ONE_Q30;
        sum  = $signed(ONE_Q30);
        for (int k = 0; k < 10; k++)
        begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[k];
            if (k % 2 == 0)
            begin
                sum = sum - $signed(term);
            end
            else
            begin
                sum = sum + $signed(term);
            end
        end
        return sum;
    endfunction

    // Largest angle whose half-angle cosine is still at least the indexed value.
    function automatic logic [qrm_pkg::ANGLE_W-1:0] acos_entry(input int idx);
        logic signed [63:0]          d;
        logic [qrm_pkg::ANGLE_W-1:0] lo;
        logic [qrm_pkg::ANGLE_W-1:0] hi;
        logic [qrm_pkg::ANGLE_W-1:0] mid;
        d  = $signed(64'(idx) << (30 - INDEX_BITS));
        lo = '0;
        hi = qrm_pkg::ANGLE_MAX;
        for (int s = 0; s < 15; s++)
        begin
            if (lo < hi)
            begin
                mid = qrm_pkg::ANGLE_W'((16'(lo) + 16'(hi) + 16'd1) >> 1);
                if (cos_q30(mid) >= d)
                begin
                    lo = mid;
                end
                else
                begin
                    hi = mid - 1'b1;
                end
            end
        end
        return lo;
    endfunction

    logic [qrm_pkg::ANGLE_W-1:0] rom_table [ENTRIES];
    logic [qrm_pkg::ANGLE_W-1:0] data_reg;

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_entry
        localparam logic [qrm_pkg::ANGLE_W-1:0] ENTRY = acos_entry(g);
        assign rom_table[g] = ENTRY;
    end

    always_ff @(posedge clk)
    begin
        if (read_en)
        begin
            data_reg <= rom_table[addr];
        end
    end

    assign data = data_reg;

endmodule

/* src/quaternion_rotation_and_motion_flags.sv */
// Quaternion rotation angle and motion flags, top level.
// An item passes the products register and then the registered angle table read before
// its result is offered. The block takes one item per cycle while the result side does not
// stall; these two registers form a two-stage pipeline, and an item enters whenever the
// first stage frees up.
// Reset clears the flags, the reference mark and the pipeline and sets the limits to
// their defaults; the angle table is constant, so there is no clearing pass.
module quaternion_rotation_and_motion_flags #(
    parameter int ACOS_INDEX_BITS = qrm_pkg::ACOS_INDEX_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    qrm_sample_if.sink                      sample,
    qrm_result_if.source                    result,
    input  logic                            cfg_write,
    input  logic [qrm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [qrm_pkg::DATA_W-1:0]      cfg_data
);

    logic                        accept;
    logic                        s1_adv;
    logic                        s2_adv;
    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    logic                        s2_valid_reg;
    logic                        s2_valid_next;
    logic                        s1_angle_reg;
    logic                        s1_taken_reg;
    qrm_pkg::flags_t             s1_flags_reg;
    logic                        s2_angle_reg;
    logic                        s2_taken_reg;
    qrm_pkg::flags_t             s2_flags_reg;
    qrm_pkg::flags_t             flags;
    qrm_pkg::rot_kind_t          kind;
    logic [ACOS_INDEX_BITS:0]    index;
    logic [qrm_pkg::ANGLE_W-1:0] rom_data;

    assign s2_adv       = !s2_valid_reg || result.ready;
    assign s1_adv       = s1_valid_reg && s2_adv;
    assign sample.ready = !s1_valid_reg || s2_adv;
    assign accept       = sample.valid && sample.ready;

    qrm_motion u_motion (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .accel_accept (accept && !sample.operation),
        .accel_x      (sample.accel_x),
        .accel_y      (sample.accel_y),
        .accel_z      (sample.accel_z),
        .flags        (flags)
    );

    qrm_dot #(
        .INDEX_BITS (ACOS_INDEX_BITS)
    ) u_dot (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .operation        (sample.operation),
        .sensor_was_reset (sample.sensor_was_reset),
        .quat_w           (sample.quat_w),
        .quat_x           (sample.quat_x),
        .quat_y           (sample.quat_y),
        .quat_z           (sample.quat_z),
        .kind             (kind),
        .index            (index)
    );

    qrm_acos_rom #(
        .INDEX_BITS (ACOS_INDEX_BITS)
    ) u_acos_rom (
        .clk     (clk),
        .read_en (s1_adv),
        .addr    (index),
        .data    (rom_data)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s2_adv)
        begin
            s1_valid_next = 1'b0;
        end
        s2_valid_next = s2_adv ? s1_valid_reg : s2_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_angle_reg <= kind.angle;
            s1_taken_reg <= kind.take;
            s1_flags_reg <= flags;
        end
        if (s1_adv)
        begin
            s2_angle_reg <= s1_angle_reg;
            s2_taken_reg <= s1_taken_reg;
            s2_flags_reg <= s1_flags_reg;
        end
    end

    assign result.valid           = s2_valid_reg;
    assign result.angle_valid     = s2_angle_reg;
    assign result.angle_centideg  = s2_angle_reg ? rom_data : '0;
    assign result.reference_taken = s2_taken_reg;
    assign result.lift_flag       = s2_flags_reg.lift;
    assign result.drop_flag       = s2_flags_reg.drop;
    assign result.left_flag       = s2_flags_reg.left;
    assign result.right_flag      = s2_flags_reg.right;
    assign result.forward_flag    = s2_flags_reg.forward;
    assign result.backward_flag   = s2_flags_reg.backward;

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_adv |=> s1_valid_reg && $stable(s1_taken_reg)
            && $stable(s1_angle_reg))
        else $error("First stage lost or changed a stalled item.");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.angle_valid |->
            !result.reference_taken && result.angle_centideg <= qrm_pkg::ANGLE_MAX)
        else $error("Angle result out of range or marked as reference.");

    a_reset_mark_takes: assert property (@(posedge clk) disable iff (!rst_n)
        accept && sample.operation && sample.sensor_was_reset |=>
            s1_valid_reg && s1_taken_reg && !s1_angle_reg)
        else $error("Rotation item after a sensor reset was not taken as reference.");

    a_accel_plain: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !sample.operation |=> !s1_taken_reg && !s1_angle_reg)
        else $error("Acceleration item marked as rotation result.");

endmodule
